@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define AST_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/fvn_pkg.sv @@
package fvn_pkg;

  localparam int MAX_OCTAVES = 16;
  localparam int OCT_W = 5;
  localparam logic [32:0] ROW_STRIDE = 33'd1000;
  localparam logic [32:0] HASH_MUL = 33'h0045d9f3b;
  localparam int ACC_W = 50;
  localparam int TOT_W = 21;
  localparam int DEN_W = TOT_W + 14;
  localparam int DIV_STEPS = ACC_W;
  localparam int DCNT_W = $clog2(DIV_STEPS);

  localparam logic [1:0] REG_OCTAVE_COUNT = 2'd0;
  localparam logic [1:0] REG_LACUNARITY = 2'd1;
  localparam logic [1:0] REG_PERSISTENCE = 2'd2;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_MSX, OP_WSX, OP_MSY, OP_WSY, OP_MROW, OP_VSUM, OP_MH,
    OP_VPRD, OP_HFIN, OP_MSQ, OP_R2W, OP_MRW, OP_WCOR, OP_DIFF, OP_MLT, OP_WLT,
    OP_MACC, OP_ACC, OP_MSC, OP_WSC, OP_MWT, OP_WWT, OP_DINIT, OP_DSTEP, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

@@ rtl/fvn_datapath.sv @@
module fvn_datapath
  import fvn_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            stat,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  input  logic [15:0]        lacunarity,
  input  logic [15:0]        persistence,
  output logic               out_valid,
  output logic signed [15:0] out_noise_value
);

  logic [31:0] x_r, x_nxt, y_r, y_nxt, scale_r, scale_nxt;
  logic [16:0] weight_r, weight_nxt;
  logic [31:0] cx_r, cx_nxt, cy_r, cy_nxt, v_r, v_nxt;
  logic [15:0] tx_r, tx_nxt, ty_r, ty_nxt;
  logic [28:0] r2_r, r2_nxt;
  logic [30:0] w_r, w_nxt;
  logic [31:0] ca_r, ca_nxt, cb_r, cb_nxt, cc_r, cc_nxt, cd_r, cd_nxt;
  logic signed [33:0] top_r, top_nxt, bot_r, bot_nxt;
  logic signed [29:0] oct_r, oct_nxt;
  logic signed [32:0] diff_r, diff_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [TOT_W-1:0] tot_r, tot_nxt;
  logic signed [65:0] prod_r, prod_nxt;
  logic [DEN_W:0] rem_r, rem_nxt;
  logic [ACC_W-1:0] dq_r, dq_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic neg_r, neg_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [15:0] out_r, out_nxt;

  logic signed [32:0] ma, mb;
  logic [31:0] ccx, ccy, xs;
  logic signed [32:0] wv;
  logic signed [33:0] la, lres, dsub;
  logic [15:0] tsel;
  logic [DEN_W+1:0] trial;
  logic [15:0] q;

  assign ccx = cx_r + {31'd0, cmd.sel[1]};
  assign ccy = cy_r + {31'd0, cmd.sel[0]};
  assign xs = {{16{v_r[31]}}, v_r[31:16]} ^ v_r;
  assign wv = 33'sd805306368 - {{3{v_r[31]}}, v_r[31:2]};
  assign tsel = (cmd.sel == 2'd2) ? ty_r : tx_r;
  assign trial = {1'b0, rem_r[DEN_W-1:0], dq_r[ACC_W-1]} - {2'b00, den_r};
  assign q = dq_r[15:0];

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MSX: begin
        ma = {x_r[31], x_r};
        mb = {1'b0, scale_r};
      end
      OP_MSY: begin
        ma = {y_r[31], y_r};
        mb = {1'b0, scale_r};
      end
      OP_MROW: begin
        ma = {1'b0, ccy};
        mb = ROW_STRIDE;
      end
      OP_MH: begin
        ma = {1'b0, xs};
        mb = HASH_MUL;
      end
      OP_MSQ: begin
        ma = {v_r[31], v_r};
        mb = {v_r[31], v_r};
      end
      OP_MRW: begin
        ma = {4'd0, r2_r};
        mb = {2'd0, w_r};
      end
      OP_MLT: begin
        ma = diff_r;
        mb = {17'd0, tsel};
      end
      OP_MACC: begin
        ma = {{3{oct_r[29]}}, oct_r};
        mb = {16'd0, weight_r};
      end
      OP_MSC: begin
        ma = {1'b0, scale_r};
        mb = {17'd0, lacunarity};
      end
      OP_MWT: begin
        ma = {16'd0, weight_r};
        mb = {17'd0, persistence};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd.sel)
      2'd0: begin
        la = {2'b00, ca_r};
        dsub = {2'b00, cc_r} - {2'b00, ca_r};
      end
      2'd1: begin
        la = {2'b00, cb_r};
        dsub = {2'b00, cd_r} - {2'b00, cb_r};
      end
      default: begin
        la = top_r;
        dsub = bot_r - top_r;
      end
    endcase
    lres = la + prod_r[49:16];
  end

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    scale_nxt = scale_r;
    weight_nxt = weight_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    tx_nxt = tx_r;
    ty_nxt = ty_r;
    v_nxt = v_r;
    r2_nxt = r2_r;
    w_nxt = w_r;
    ca_nxt = ca_r;
    cb_nxt = cb_r;
    cc_nxt = cc_r;
    cd_nxt = cd_r;
    top_nxt = top_r;
    bot_nxt = bot_r;
    oct_nxt = oct_r;
    diff_nxt = diff_r;
    acc_nxt = acc_r;
    tot_nxt = tot_r;
    prod_nxt = ma * mb;
    rem_nxt = rem_r;
    dq_nxt = dq_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    dcnt_nxt = dcnt_r;
    out_valid_nxt = 1'b0;
    out_nxt = out_r;
    case (cmd.op)
      OP_LOAD: begin
        x_nxt = in_x_coord;
        y_nxt = in_y_coord;
        scale_nxt = 32'h0001_0000;
        weight_nxt = 17'h1_0000;
        acc_nxt = '0;
        tot_nxt = '0;
      end
      OP_WSX: begin
        cx_nxt = {{16{prod_r[47]}}, prod_r[47:32]};
        tx_nxt = prod_r[31:16];
      end
      OP_WSY: begin
        cy_nxt = {{16{prod_r[47]}}, prod_r[47:32]};
        ty_nxt = prod_r[31:16];
      end
      OP_VSUM: v_nxt = ccx + prod_r[31:0];
      OP_VPRD: v_nxt = prod_r[31:0];
      OP_HFIN: v_nxt = xs;
      OP_R2W: begin
        r2_nxt = prod_r[62:34];
        w_nxt = wv[30:0];
      end
      OP_WCOR: begin
        case (cmd.sel)
          2'd0: ca_nxt = prod_r[59:28];
          2'd1: cb_nxt = prod_r[59:28];
          2'd2: cc_nxt = prod_r[59:28];
          default: cd_nxt = prod_r[59:28];
        endcase
      end
      OP_DIFF: diff_nxt = dsub[32:0];
      OP_WLT: begin
        case (cmd.sel)
          2'd0: top_nxt = lres;
          2'd1: bot_nxt = lres;
          default: begin
            if (lres < -34'sd268435456) begin
              oct_nxt = -30'sd268435456;
            end else if (lres > 34'sd268435456) begin
              oct_nxt = 30'sd268435456;
            end else begin
              oct_nxt = lres[29:0];
            end
          end
        endcase
      end
      OP_ACC: begin
        acc_nxt = acc_r + prod_r[ACC_W-1:0];
        tot_nxt = tot_r + {{(TOT_W-17){1'b0}}, weight_r};
      end
      OP_WSC: scale_nxt = prod_r[39:8];
      OP_WWT: weight_nxt = prod_r[32:16];
      OP_DINIT: begin
        neg_nxt = acc_r[ACC_W-1];
        dq_nxt = acc_r[ACC_W-1] ? -acc_r : acc_r;
        den_nxt = {tot_r, 14'd0};
        rem_nxt = '0;
        dcnt_nxt = '0;
      end
      OP_DSTEP: begin
        dcnt_nxt = dcnt_r + 1'b1;
        if (!trial[DEN_W+1]) begin
          rem_nxt = trial[DEN_W:0];
          dq_nxt = {dq_r[ACC_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[DEN_W-1:0], dq_r[ACC_W-1]};
          dq_nxt = {dq_r[ACC_W-2:0], 1'b0};
        end
      end
      OP_OUT: begin
        out_valid_nxt = 1'b1;
        out_nxt = neg_r ? -q : q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    scale_r <= scale_nxt;
    weight_r <= weight_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    tx_r <= tx_nxt;
    ty_r <= ty_nxt;
    v_r <= v_nxt;
    r2_r <= r2_nxt;
    w_r <= w_nxt;
    ca_r <= ca_nxt;
    cb_r <= cb_nxt;
    cc_r <= cc_nxt;
    cd_r <= cd_nxt;
    top_r <= top_nxt;
    bot_r <= bot_nxt;
    oct_r <= oct_nxt;
    diff_r <= diff_nxt;
    acc_r <= acc_nxt;
    tot_r <= tot_nxt;
    prod_r <= prod_nxt;
    rem_r <= rem_nxt;
    dq_r <= dq_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    dcnt_r <= dcnt_nxt;
    out_r <= out_nxt;
  end

  assign stat.div_last = (dcnt_r == DCNT_W'(DIV_STEPS - 1));
  assign out_valid = out_valid_r;
  assign out_noise_value = out_r;

endmodule

@@ rtl/fvn_ctrl.sv @@
`include "assert_macros.svh"
module fvn_ctrl
  import fvn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [OCT_W-1:0] octave_count,
  input  status_t          stat,
  output cmd_t             cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_COORD = 9'b000000010,
    S_CORN  = 9'b000000100,
    S_LERP  = 9'b000001000,
    S_UPD   = 9'b000010000,
    S_DINIT = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_OUT   = 9'b010000000
  } state_t;

  localparam logic [3:0] COORD_LAST = 4'd3;
  localparam logic [3:0] CORN_LAST = 4'd10;
  localparam logic [3:0] LERP_LAST = 4'd2;
  localparam logic [3:0] UPD_LAST = 4'd5;

  state_t state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [OCT_W-1:0] oct_r, oct_nxt, n_r, n_nxt, n_sat;

  function automatic op_t coord_op(input logic [1:0] s);
    case (s)
      2'd0: coord_op = OP_MSX;
      2'd1: coord_op = OP_WSX;
      2'd2: coord_op = OP_MSY;
      default: coord_op = OP_WSY;
    endcase
  endfunction

  function automatic op_t corner_op(input logic [3:0] s);
    case (s)
      4'd0: corner_op = OP_MROW;
      4'd1: corner_op = OP_VSUM;
      4'd2: corner_op = OP_MH;
      4'd3: corner_op = OP_VPRD;
      4'd4: corner_op = OP_MH;
      4'd5: corner_op = OP_VPRD;
      4'd6: corner_op = OP_HFIN;
      4'd7: corner_op = OP_MSQ;
      4'd8: corner_op = OP_R2W;
      4'd9: corner_op = OP_MRW;
      4'd10: corner_op = OP_WCOR;
      default: corner_op = OP_NOP;
    endcase
  endfunction

  function automatic op_t lerp_op(input logic [1:0] s);
    case (s)
      2'd0: lerp_op = OP_DIFF;
      2'd1: lerp_op = OP_MLT;
      2'd2: lerp_op = OP_WLT;
      default: lerp_op = OP_NOP;
    endcase
  endfunction

  function automatic op_t upd_op(input logic [2:0] s);
    case (s)
      3'd0: upd_op = OP_MACC;
      3'd1: upd_op = OP_ACC;
      3'd2: upd_op = OP_MSC;
      3'd3: upd_op = OP_WSC;
      3'd4: upd_op = OP_MWT;
      3'd5: upd_op = OP_WWT;
      default: upd_op = OP_NOP;
    endcase
  endfunction

  always_comb begin
    if (octave_count == '0) begin
      n_sat = OCT_W'(1);
    end else if (octave_count > OCT_W'(MAX_OCTAVES)) begin
      n_sat = OCT_W'(MAX_OCTAVES);
    end else begin
      n_sat = octave_count;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    sub_nxt = sub_r;
    oct_nxt = oct_r;
    n_nxt = n_r;
    cmd.op = OP_NOP;
    cmd.sel = sub_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          state_nxt = S_COORD;
          step_nxt = '0;
          sub_nxt = '0;
          oct_nxt = '0;
          n_nxt = n_sat;
        end
      end
      S_COORD: begin
        cmd.op = coord_op(step_r[1:0]);
        if (step_r == COORD_LAST) begin
          step_nxt = '0;
          sub_nxt = '0;
          state_nxt = S_CORN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_CORN: begin
        cmd.op = corner_op(step_r);
        if (step_r == CORN_LAST) begin
          step_nxt = '0;
          if (sub_r == 2'd3) begin
            sub_nxt = '0;
            state_nxt = S_LERP;
          end else begin
            sub_nxt = sub_r + 1'b1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_LERP: begin
        cmd.op = lerp_op(step_r[1:0]);
        if (step_r == LERP_LAST) begin
          step_nxt = '0;
          if (sub_r == 2'd2) begin
            sub_nxt = '0;
            state_nxt = S_UPD;
          end else begin
            sub_nxt = sub_r + 1'b1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_UPD: begin
        cmd.op = upd_op(step_r[2:0]);
        if (step_r == UPD_LAST) begin
          step_nxt = '0;
          oct_nxt = oct_r + 1'b1;
          if (oct_r + 1'b1 == n_r) begin
            state_nxt = S_DINIT;
          end else begin
            state_nxt = S_COORD;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DINIT: begin
        cmd.op = OP_DINIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DSTEP;
        if (stat.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        cmd.op = OP_OUT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
      sub_r <= '0;
      oct_r <= '0;
      n_r <= OCT_W'(1);
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      sub_r <= sub_nxt;
      oct_r <= oct_nxt;
      n_r <= n_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `AST_IMPLY(a_load_idle, clk, rst_n, cmd.op == OP_LOAD, state_r == S_IDLE, "item load outside idle")
  `AST_NEXT(a_div_out, clk, rst_n, state_r == S_DIV && stat.div_last, state_r == S_OUT, "divide end missed")
  `AST_NEXT(a_out_idle, clk, rst_n, state_r == S_OUT, !busy, "busy after result")
  `AST_IMPLY(a_oct_range, clk, rst_n, busy, oct_r <= n_r, "octave count overrun")

endmodule

@@ rtl/fractal_value_noise_2d_core.sv @@
// Fractal 2-D value noise over signed Q16.16 points, result in signed Q1.14. An item is
// taken when start is high and busy is low; busy stays high until the item is done. The
// sequencer runs each octave through one shared 33x33 multiplier (coordinate scaling,
// four corner hashes, three interpolations, accumulation, weight and scale updates),
// then a restoring divide. The octave count is saturated to 1..16. out_valid is high
// for one cycle with out_noise_value; the receiver cannot stall it, and the next item
// may start in that same cycle.
module fractal_value_noise_2d_core
  import fvn_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  output logic               out_valid,
  output logic signed [15:0] out_noise_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [15:0]        cfg_data
);

  logic [OCT_W-1:0] octave_count_r;
  logic [15:0] lacunarity_r, persistence_r;
  cmd_t cmd;
  status_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= OCT_W'(4);
      lacunarity_r <= 16'd512;
      persistence_r <= 16'd32768;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_OCTAVE_COUNT: octave_count_r <= cfg_data[OCT_W-1:0];
        REG_LACUNARITY: lacunarity_r <= cfg_data;
        REG_PERSISTENCE: persistence_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fvn_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .octave_count(octave_count_r),
    .stat(stat),
    .cmd(cmd)
  );

  fvn_datapath u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .stat(stat),
    .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord),
    .lacunarity(lacunarity_r),
    .persistence(persistence_r),
    .out_valid(out_valid),
    .out_noise_value(out_noise_value)
  );

endmodule

@@ tb/sv/tb_fractal_value_noise_2d_core.sv @@
module tb_fractal_value_noise_2d_core;
  import fvn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RAND_ITEMS = 430;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    bit          known;
    logic [15:0] noise;
  } point_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_x_coord = '0;
  logic signed [31:0] in_y_coord = '0;
  logic               out_valid;
  logic signed [15:0] out_noise_value;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_idx = '0;
  logic [15:0]        cfg_data = '0;

  logic [4:0]  octaves_r = 5'd4;
  logic [15:0] lacunarity_r = 16'd512;
  logic [15:0] persistence_r = 16'd32768;

  logic [15:0] noise_expected[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          cfg_writes = 0;
  int          cycles = 0;

  fractal_value_noise_2d_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_x_coord(in_x_coord), .in_y_coord(in_y_coord),
    .out_valid(out_valid), .out_noise_value(out_noise_value),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] asr16(logic [31:0] v);
    return {{16{v[31]}}, v[31:16]};
  endfunction

  function automatic longint lattice_value(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] v;
    longint h, r2, w;
    v = cx + 32'd1000 * cy;
    v = (asr16(v) ^ v) * 32'h045d9f3b;
    v = (asr16(v) ^ v) * 32'h045d9f3b;
    v = asr16(v) ^ v;
    h = longint'($signed(v));
    r2 = (h * h) >>> 34;
    w = 3 * (longint'(1) <<< 28) - (h >>> 2);
    return (r2 * w) >>> 28;
  endfunction

  function automatic longint blend(longint a, longint b, logic [15:0] t);
    return a + (((b - a) * longint'(t)) >>> 16);
  endfunction

  function automatic logic [31:0] scaled(logic [31:0] c, logic [31:0] s);
    logic [63:0] p;
    p = longint'($signed(c)) * longint'(s);
    return p[47:16];
  endfunction

  function automatic longint layer_value(logic [31:0] sx, logic [31:0] sy);
    logic [31:0] cx, cy;
    longint top, bot, r;
    cx = asr16(sx);
    cy = asr16(sy);
    top = blend(lattice_value(cx, cy), lattice_value(cx + 1, cy), sx[15:0]);
    bot = blend(lattice_value(cx, cy + 1), lattice_value(cx + 1, cy + 1), sx[15:0]);
    r = blend(top, bot, sy[15:0]);
    if (r < -(longint'(1) <<< 28)) r = -(longint'(1) <<< 28);
    if (r > (longint'(1) <<< 28)) r = longint'(1) <<< 28;
    return r;
  endfunction

  function automatic logic [15:0] predict_noise(logic [31:0] x, logic [31:0] y);
    int          n;
    logic [31:0] s;
    logic [63:0] wide;
    logic [63:0] weight;
    longint      acc, tot, q;
    n = octaves_r;
    s = 32'd65536;
    weight = 64'd65536;
    acc = 0;
    tot = 0;
    if (n < 1) n = 1;
    if (n > MAX_OCTAVES) n = MAX_OCTAVES;
    for (int i = 0; i < n; i++) begin
      acc += layer_value(scaled(x, s), scaled(y, s)) * longint'(weight);
      tot += longint'(weight);
      wide = {32'b0, s} * {48'b0, lacunarity_r};
      s = wide[39:8];
      weight = (weight * {48'b0, persistence_r}) >> 16;
    end
    q = acc / (tot <<< 14);
    return q[15:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (noise_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected noise %h", out_noise_value));
      end else begin
        logic [15:0] want;
        want = noise_expected.pop_front();
        if (out_noise_value !== want)
          report_mismatch($sformatf("noise %h, expected %h", out_noise_value, want));
      end
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, bit known, logic [15:0] noise);
    start <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    do @(posedge clk); while (busy);
    noise_expected.push_back(known ? noise : predict_noise(x, y));
    items_sent++;
  endtask

  task automatic gap_after_item();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) :
        ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (noise_expected.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OCTAVE_COUNT: octaves_r = data[4:0];
      REG_LACUNARITY:   lacunarity_r = data;
      REG_PERSISTENCE:  persistence_r = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_config(logic [15:0] oct, logic [15:0] lac, logic [15:0] per);
    drain();
    write_reg(REG_OCTAVE_COUNT, oct);
    write_reg(REG_LACUNARITY, lac);
    write_reg(REG_PERSISTENCE, per);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000))) - 32'd1000000;
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 40000000))) - 32'd20000000;
    endcase
  endfunction

  point_row_t directed[] = '{
    '{32'h00000000, 32'h00000000, 1'b1, 16'h0000},
    '{32'h7fffffff, 32'h7fffffff, 1'b0, 16'h0},
    '{32'h80000000, 32'h80000000, 1'b0, 16'h0},
    '{32'h7fffffff, 32'h80000000, 1'b0, 16'h0},
    '{32'h80000000, 32'h7fffffff, 1'b0, 16'h0},
    '{32'hffffffff, 32'hffffffff, 1'b0, 16'h0},
    '{32'h00010000, 32'h00000000, 1'b0, 16'h0},
    '{32'h00000000, 32'h00010000, 1'b0, 16'h0},
    '{32'h00008000, 32'h00008000, 1'b0, 16'h0},
    '{32'hffff8000, 32'h00018000, 1'b0, 16'h0},
    '{32'h0000ffff, 32'hffff0001, 1'b0, 16'h0},
    '{32'h12345678, 32'hedcba987, 1'b0, 16'h0},
    '{32'h00fa0000, 32'hff060000, 1'b0, 16'h0},
    '{32'h55555555, 32'haaaaaaaa, 1'b0, 16'h0},
    '{32'haaaaaaaa, 32'h55555555, 1'b0, 16'h0}
  };

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_point(directed[i].x, directed[i].y, directed[i].known, directed[i].noise);
      gap_after_item();
    end
    set_config(16'd1, 16'd0, 16'd0);
    foreach (directed[i]) send_point(directed[i].x, directed[i].y, directed[i].known, 16'h0);
    set_config(16'd16, 16'hffff, 16'hffff);
    for (int i = 0; i < 5; i++) send_point(directed[i].x, directed[i].y, 1'b0, 16'h0);
    set_config(16'd0, 16'd256, 16'd1);
    for (int i = 1; i < 5; i++) send_point(directed[i].x, directed[i].y, 1'b0, 16'h0);
    set_config(16'hffff, 16'd384, 16'd40000);
    for (int i = 1; i < 4; i++) send_point(directed[i].x, directed[i].y, 1'b0, 16'h0);
    drain();
    write_reg(2'd3, 16'hffff);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0) begin
        logic [15:0] oct;
        oct = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 31)) :
              16'($urandom_range(1, 6)) | (16'($urandom()) & 16'hffe0);
        set_config(oct, 16'($urandom()), 16'($urandom()));
      end
      send_point(rand_coord(), rand_coord(), 1'b0, 16'h0);
      gap_after_item();
    end

    drain();
    repeat (1200) @(posedge clk);
    $display("sent %0d items, checked %0d results, %0d register writes",
             items_sent, results_seen, cfg_writes);
    $display("octave counts 0..31, lacunarity and persistence at both extremes");
    if (mismatches == 0 && noise_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/fvn_pkg.sv
rtl/fvn_datapath.sv
rtl/fvn_ctrl.sv
rtl/fractal_value_noise_2d_core.sv
tb/sv/tb_fractal_value_noise_2d_core.sv
